[sv/ptpb_pkg.sv]
// Package for the phase triplet pixel binning block.
// Holds the pixel and result transaction types, register indexes, mode codes and sizes.
// No dependencies.
package ptpb_pkg;

  localparam int PHASE_BITS = 16;
  localparam int SUM_BITS = 20;
  localparam int OUT_BITS = 22;
  localparam int CFG_BITS = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int MAX_SHIFT = 4;

  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_BIN_MODE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SUM_SHIFT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROI_WIDTH = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROI_HEIGHT = 2'd3;

  localparam logic [2:0] MODE_PASS = 3'd0;
  localparam logic [2:0] MODE_H2 = 3'd1;
  localparam logic [2:0] MODE_H4 = 3'd2;
  localparam logic [2:0] MODE_2X2 = 3'd3;
  localparam logic [2:0] MODE_4X4 = 3'd4;

  localparam logic [2:0] RST_BIN_MODE = MODE_PASS;
  localparam logic [2:0] RST_SUM_SHIFT = 3'd1;
  localparam logic [CFG_BITS-1:0] RST_ROI_SIZE = 11'd1024;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_a;
    logic [PHASE_BITS-1:0] phase_b;
    logic [PHASE_BITS-1:0] phase_c;
  } pixel_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] out_a;
    logic [OUT_BITS-1:0] out_b;
    logic [OUT_BITS-1:0] out_c;
    logic                row_end;
    logic                frame_end;
  } result_t;

endpackage

[sv/phase_triplet_pixel_binning.sv]
// Phase triplet pixel binning: sums three phase samples over 1x1, 1x2, 1x4, 2x2 or 4x4 bins.
// An accepted pixel passes the stage register s1 and then the result register; one pixel
// is taken per cycle unless a stalled result holds the stage register.
// A synchronous active-high reset clears the counters, pipeline valids, configuration registers and running sums.
// The line store is not cleared; each entry is written on a bin's first row before use.
// Depends on ptpb_pkg.
module phase_triplet_pixel_binning
  import ptpb_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      pix_valid,
  output logic                      pix_ready,
  input  pixel_t                    pix,
  output logic                      bin_valid,
  input  logic                      bin_ready,
  output result_t                   bin
);

  localparam int CNT_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);
  localparam int SZ_W = CNT_BITS + 1;
  localparam int SZ_H = ROW_BITS + 1;
  localparam int CMP_W = (SZ_W > CFG_BITS) ? SZ_W : CFG_BITS;
  localparam int CMP_H = (SZ_H > CFG_BITS) ? SZ_H : CFG_BITS;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_BITS = $clog2(LINE_DEPTH);
  localparam logic [PHASE_BITS-1:0] PHASE_MASK =
    (SAMPLE_BITS >= PHASE_BITS) ? {PHASE_BITS{1'b1}}
                                : PHASE_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  typedef struct packed {
    logic [SUM_BITS-1:0] px_a;
    logic [SUM_BITS-1:0] px_b;
    logic [SUM_BITS-1:0] px_c;
    logic                first;
    logic                mode_ok;
    logic                done;
    logic                last_y;
    logic                use_line;
    logic                re;
    logic                fe;
    logic [2:0]          shift;
    logic [IDX_BITS-1:0] idx;
  } stage_t;

  logic [2:0]          bin_mode;
  logic [2:0]          sum_shift;
  logic [CFG_BITS-1:0] roi_width;
  logic [CFG_BITS-1:0] roi_height;

  logic [CNT_BITS-1:0] column_count;
  logic [ROW_BITS-1:0] row_count;
  logic [SUM_BITS-1:0] hsum [3];
  logic [3*SUM_BITS-1:0] line_mem [LINE_DEPTH];
  logic [3*SUM_BITS-1:0] line_rd;

  logic   s1_valid;
  stage_t s1;
  stage_t s1_next;
  logic   s1_go;
  logic   pix_fire;

  logic [CMP_W-1:0]    w_ext;
  logic [CMP_H-1:0]    h_ext;
  logic [SZ_W-1:0]     w;
  logic [SZ_H-1:0]     h;
  logic [1:0]          bx_log;
  logic [1:0]          by_log;
  logic [1:0]          bx_mask;
  logic [1:0]          by_mask;
  logic                mode_ok;
  logic [2:0]          shift;
  logic [SZ_W-1:0]     bins_x;
  logic [SZ_H-1:0]     bins_y;
  logic [CNT_BITS-1:0] idx_full;
  logic [ROW_BITS-1:0] row_bin;
  logic                in_roi;
  logic                line_ok;
  logic                last_x;
  logic                row_wrap;
  logic                frame_wrap;

  logic [SUM_BITS-1:0] hsum_next [3];
  logic [SUM_BITS-1:0] px [3];
  logic [SUM_BITS-1:0] prev [3];
  logic [SUM_BITS-1:0] total [3];
  logic [OUT_BITS-1:0] scaled [3];

  assign cfg_ready = 1'b1;
  assign s1_go = !bin_valid || bin_ready;
  assign pix_ready = !s1_valid || s1_go;
  assign pix_fire = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_mode <= RST_BIN_MODE;
      sum_shift <= RST_SUM_SHIFT;
      roi_width <= RST_ROI_SIZE;
      roi_height <= RST_ROI_SIZE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BIN_MODE:   bin_mode <= cfg_data[2:0];
        CFG_SUM_SHIFT:  sum_shift <= cfg_data[2:0];
        CFG_ROI_WIDTH:  roi_width <= cfg_data;
        CFG_ROI_HEIGHT: roi_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_ext = CMP_W'(roi_width);
    h_ext = CMP_H'(roi_height);
    if (w_ext == '0) begin
      w = SZ_W'(1);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      w = SZ_W'(MAX_WIDTH);
    end else begin
      w = w_ext[SZ_W-1:0];
    end
    if (h_ext == '0) begin
      h = SZ_H'(1);
    end else if (h_ext > CMP_H'(MAX_HEIGHT)) begin
      h = SZ_H'(MAX_HEIGHT);
    end else begin
      h = h_ext[SZ_H-1:0];
    end

    bx_log = 2'd0;
    by_log = 2'd0;
    mode_ok = 1'b1;
    shift = 3'd0;
    unique case (bin_mode)
      MODE_PASS: begin
      end
      MODE_H2: bx_log = 2'd1;
      MODE_H4: bx_log = 2'd2;
      MODE_2X2: begin
        bx_log = 2'd1;
        by_log = 2'd1;
        shift = (sum_shift > 3'(MAX_SHIFT)) ? 3'(MAX_SHIFT) : sum_shift;
      end
      MODE_4X4: begin
        bx_log = 2'd2;
        by_log = 2'd2;
      end
      default: mode_ok = 1'b0;
    endcase

    bx_mask = {bx_log[1], bx_log != 2'd0};
    by_mask = {by_log[1], by_log != 2'd0};
    bins_x = w >> bx_log;
    bins_y = h >> by_log;
    idx_full = column_count >> bx_log;
    row_bin = row_count >> by_log;
    in_roi = (SZ_W'(idx_full) < bins_x) && (SZ_H'(row_bin) < bins_y);
    line_ok = (by_log == 2'd0) || (idx_full < CNT_BITS'(LINE_DEPTH));
    last_x = (column_count[1:0] & bx_mask) == bx_mask;
    row_wrap = (SZ_W'(column_count) + SZ_W'(1)) >= w;
    frame_wrap = (SZ_H'(row_count) + SZ_H'(1)) >= h;

    s1_next.px_a = SUM_BITS'(pix.phase_a & PHASE_MASK);
    s1_next.px_b = SUM_BITS'(pix.phase_b & PHASE_MASK);
    s1_next.px_c = SUM_BITS'(pix.phase_c & PHASE_MASK);
    s1_next.first = (column_count[1:0] & bx_mask) == 2'd0;
    s1_next.mode_ok = mode_ok;
    s1_next.done = mode_ok && last_x && in_roi && line_ok;
    s1_next.last_y = (row_count[1:0] & by_mask) == by_mask;
    s1_next.use_line = (row_count[1:0] & by_mask) != 2'd0;
    s1_next.re = SZ_W'(idx_full) == (bins_x - SZ_W'(1));
    s1_next.fe = s1_next.re && (SZ_H'(row_bin) == (bins_y - SZ_H'(1)));
    s1_next.shift = shift;
    s1_next.idx = idx_full[IDX_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (pix_fire) begin
        s1_valid <= 1'b1;
        if (row_wrap) begin
          column_count <= '0;
          row_count <= frame_wrap ? '0 : row_count + ROW_BITS'(1);
        end else begin
          column_count <= column_count + CNT_BITS'(1);
        end
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1 <= s1_next;
      line_rd <= line_mem[s1_next.idx];
    end
    if (s1_valid && s1_go && s1.done && !s1.last_y) begin
      line_mem[s1.idx] <= {total[0], total[1], total[2]};
    end
  end

  always_comb begin
    px[0] = s1.px_a;
    px[1] = s1.px_b;
    px[2] = s1.px_c;
    prev[0] = s1.use_line ? line_rd[3*SUM_BITS-1:2*SUM_BITS] : '0;
    prev[1] = s1.use_line ? line_rd[2*SUM_BITS-1:SUM_BITS] : '0;
    prev[2] = s1.use_line ? line_rd[SUM_BITS-1:0] : '0;
    for (int p = 0; p < 3; p++) begin
      hsum_next[p] = s1.first ? px[p] : hsum[p] + px[p];
      total[p] = prev[p] + hsum_next[p];
      scaled[p] = OUT_BITS'((OUT_BITS + MAX_SHIFT)'(total[p]) << s1.shift);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < 3; p++) begin
        hsum[p] <= '0;
      end
    end else if (s1_valid && s1_go && s1.mode_ok) begin
      for (int p = 0; p < 3; p++) begin
        hsum[p] <= hsum_next[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else if (s1_go) begin
      bin_valid <= s1_valid && s1.done && s1.last_y;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_valid && s1.done && s1.last_y) begin
      bin.out_a <= scaled[0];
      bin.out_b <= scaled[1];
      bin.out_c <= scaled[2];
      bin.row_end <= s1.re;
      bin.frame_end <= s1.fe;
    end
  end

`ifndef SYNTHESIS
  // A frame always ends on the last bin of a row.
  assert property (@(posedge clk) disable iff (rst) bin_valid |-> (!bin.frame_end || bin.row_end))
    else $error("frame_end raised without row_end");

  // A stalled result and a held pixel must block new pixel transactions.
  assert property (@(posedge clk) disable iff (rst) (s1_valid && !s1_go) |-> !pix_ready)
    else $error("pixel accepted while the stage register is stalled");

  // The column counter returns to zero after the last pixel of a row.
  assert property (@(posedge clk) disable iff (rst) (pix_fire && row_wrap) |=> (column_count == '0))
    else $error("column counter did not wrap at the end of a row");

  // A held result cannot be replaced before it is taken.
  assert property (@(posedge clk) disable iff (rst) (bin_valid && !bin_ready) |=> bin_valid)
    else $error("pending binned pixel was dropped");
`endif

endmodule

[test/ptpb_checker.sv]
`timescale 1ns / 100ps
// Checker for phase_triplet_pixel_binning: follows the register writes, predicts the binned
// pixel that each accepted pixel transaction completes and compares every accepted result.
// Depends on ptpb_pkg.
module ptpb_checker
  import ptpb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      pix_valid,
  input  logic                      pix_ready,
  input  pixel_t                    pix,
  input  logic                      bin_valid,
  input  logic                      bin_ready,
  input  result_t                   bin,
  output int                        pending,
  output int                        fails
);

  localparam int LINE_DEPTH = DEF_MAX_WIDTH / 2;
  localparam int PRINT_LIMIT = 100;

  logic [2:0]          mode_q;
  logic [2:0]          shift_q;
  logic [CFG_BITS-1:0] width_q;
  logic [CFG_BITS-1:0] height_q;
  int unsigned         col_pos;
  int unsigned         row_pos;
  logic [SUM_BITS-1:0] run_sum [3];
  logic [SUM_BITS-1:0] line_sum [LINE_DEPTH][3];
  result_t             expected_bins [$];
  int                  mismatches = 0;
  int                  checked = 0;

  assign fails = mismatches;

  task automatic flag(input string msg);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: mismatch on binned pixel %0d: %s", $time, checked, msg);
    end
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [OUT_BITS-1:0] got,
                               input logic [OUT_BITS-1:0] want);
    if (got !== want) begin
      flag($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  function automatic int unsigned clamp_dim(input logic [CFG_BITS-1:0] v,
                                            input int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Advances the raster position by one pixel and returns 1 when the pixel closes a bin.
  function automatic bit bin_pixel(input pixel_t p, output result_t r);
    int unsigned         w, h, bx, by, sh, bins_x, bins_y, xp, yp, idx;
    logic [SUM_BITS-1:0] sample [3];
    logic [SUM_BITS-1:0] total [3];
    logic [OUT_BITS-1:0] scaled [3];
    bit                  hit;
    w = clamp_dim(width_q, DEF_MAX_WIDTH);
    h = clamp_dim(height_q, DEF_MAX_HEIGHT);
    sample[0] = SUM_BITS'(p.phase_a);
    sample[1] = SUM_BITS'(p.phase_b);
    sample[2] = SUM_BITS'(p.phase_c);
    sh = 0;
    hit = 1'b0;
    r = '0;
    case (mode_q)
      MODE_PASS: begin
        bx = 1;
        by = 1;
      end
      MODE_H2: begin
        bx = 2;
        by = 1;
      end
      MODE_H4: begin
        bx = 4;
        by = 1;
      end
      MODE_2X2: begin
        bx = 2;
        by = 2;
        sh = (shift_q > MAX_SHIFT) ? MAX_SHIFT : shift_q;
      end
      MODE_4X4: begin
        bx = 4;
        by = 4;
      end
      default: begin
        bx = 0;
        by = 0;
      end
    endcase
    if (bx != 0) begin
      bins_x = w / bx;
      bins_y = h / by;
      xp = col_pos % bx;
      yp = row_pos % by;
      idx = col_pos / bx;
      for (int i = 0; i < 3; i++) begin
        run_sum[i] = (xp == 0) ? sample[i] : run_sum[i] + sample[i];
      end
      if (xp == bx - 1 && idx < bins_x && row_pos / by < bins_y) begin
        for (int i = 0; i < 3; i++) begin
          total[i] = ((yp == 0 || by == 1) ? '0 : line_sum[idx][i]) + run_sum[i];
        end
        if (yp == by - 1) begin
          for (int i = 0; i < 3; i++) begin
            scaled[i] = {{(OUT_BITS-SUM_BITS){1'b0}}, total[i]} << sh;
          end
          r.out_a = scaled[0];
          r.out_b = scaled[1];
          r.out_c = scaled[2];
          r.row_end = (idx == bins_x - 1);
          r.frame_end = r.row_end && (row_pos / by == bins_y - 1);
          hit = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            line_sum[idx][i] = total[i];
          end
        end
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return hit;
  endfunction

  always @(posedge clk) begin : watch
    result_t predicted;
    result_t want;
    if (rst) begin
      mode_q = RST_BIN_MODE;
      shift_q = RST_SUM_SHIFT;
      width_q = RST_ROI_SIZE;
      height_q = RST_ROI_SIZE;
      col_pos = 0;
      row_pos = 0;
      for (int i = 0; i < 3; i++) begin
        run_sum[i] = '0;
      end
      expected_bins.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIN_MODE: mode_q = cfg_data[2:0];
          CFG_SUM_SHIFT: shift_q = cfg_data[2:0];
          CFG_ROI_WIDTH: width_q = cfg_data;
          CFG_ROI_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) begin
        if (bin_pixel(pix, predicted)) begin
          expected_bins.push_back(predicted);
        end
      end
      if (bin_valid && bin_ready) begin
        if (expected_bins.size() == 0) begin
          flag("binned pixel arrived with none expected");
        end else begin
          want = expected_bins.pop_front();
          compare_field("out_a", bin.out_a, want.out_a);
          compare_field("out_b", bin.out_b, want.out_b);
          compare_field("out_c", bin.out_c, want.out_c);
          compare_field("row_end", OUT_BITS'(bin.row_end), OUT_BITS'(want.row_end));
          compare_field("frame_end", OUT_BITS'(bin.frame_end), OUT_BITS'(want.frame_end));
        end
        checked++;
      end
    end
    pending <= expected_bins.size();
  end

endmodule

[test/phase_triplet_pixel_binning_tb.sv]
`timescale 1ns / 100ps
// Testbench top for phase_triplet_pixel_binning: writes registers, sends pixel transactions,
// applies output backpressure and gives the verdict from the checker's mismatch count.
// Depends on ptpb_pkg, phase_triplet_pixel_binning and ptpb_checker.
module phase_triplet_pixel_binning_tb;
  import ptpb_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PIXELS = 250;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_FULL} fill_e;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data = '0;
  logic                      pix_valid = 1'b0;
  logic                      pix_ready;
  pixel_t                    pix = '0;
  logic                      bin_valid;
  logic                      bin_ready = 1'b0;
  result_t                   bin;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  int          pending_bins;
  int          mismatches;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  phase_triplet_pixel_binning dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .bin_valid(bin_valid),
    .bin_ready(bin_ready),
    .bin      (bin)
  );

  ptpb_checker check_inst (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix),
    .bin_valid(bin_valid),
    .bin_ready(bin_ready),
    .bin      (bin),
    .pending  (pending_bins),
    .fails    (mismatches)
  );

  always @(posedge clk) begin
    bin_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (bin_valid && bin_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("phase_triplet_pixel_binning_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(input int unsigned gap, input int unsigned stall);
    gap_pct = gap;
    stall_pct <= stall;
  endtask

  task automatic set_regs(input logic [2:0] mode, input logic [2:0] shift,
                          input logic [CFG_BITS-1:0] width, input logic [CFG_BITS-1:0] height);
    logic [CFG_INDEX_BITS-1:0] order [4];
    logic [CFG_BITS-1:0]       value [4];
    order = '{CFG_BIN_MODE, CFG_SUM_SHIFT, CFG_ROI_WIDTH, CFG_ROI_HEIGHT};
    value = '{{8'd0, mode}, {8'd0, shift}, width, height};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= value[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PHASE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PHASE_BITS'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < gap_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix <= p;
    do @(posedge clk); while (!pix_ready);
  endtask

  task automatic send_run(input int unsigned count, input fill_e fill);
    pixel_t p;
    for (int unsigned n = 0; n < count; n++) begin
      case (fill)
        FILL_ZERO: p = '0;
        FILL_FULL: p = '1;
        default: p = '{random_sample(), random_sample(), random_sample()};
      endcase
      send_pixel(p);
    end
  endtask

  // Waits until every predicted binned pixel has been taken, then lets the pipeline drain.
  task automatic wait_idle();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending_bins != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned frames;
    int unsigned w;
    int unsigned h;
    logic [2:0]  mode;
    sent = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_idling(0, 0);

    set_regs(MODE_PASS, 1, 2, 1);
    send_run(2, FILL_ZERO);
    send_run(2, FILL_FULL);
    wait_idle();
    set_regs(MODE_H2, 0, 4, 1);
    send_run(4, FILL_FULL);
    wait_idle();
    set_regs(MODE_H4, 2, 4, 1);
    send_run(4, FILL_FULL);
    wait_idle();
    set_regs(MODE_2X2, 4, 2, 2);
    send_run(4, FILL_FULL);
    wait_idle();
    set_regs(MODE_4X4, 3, 4, 4);
    send_run(16, FILL_FULL);
    wait_idle();
    set_regs(MODE_UNUSED, 7, 0, 0);
    send_run(3, FILL_RANDOM);
    wait_idle();

    set_regs(MODE_2X2, 1, 128, 2);
    send_run(256, FILL_RANDOM);
    wait_idle();
    set_regs(MODE_PASS, 0, 1, 64);
    send_run(64, FILL_RANDOM);
    wait_idle();

    // The row shrinks under the column counter, then the frame under the row counter.
    set_regs(MODE_H2, 0, 2047, 4);
    send_run(5, FILL_RANDOM);
    wait_idle();
    set_regs(MODE_H2, 0, 3, 4);
    send_run(10, FILL_RANDOM);
    wait_idle();
    set_regs(MODE_PASS, 0, 1, 2047);
    send_run(3, FILL_RANDOM);
    wait_idle();
    set_regs(MODE_PASS, 0, 1, 2);
    send_run(1, FILL_RANDOM);
    wait_idle();

    while (sent < RANDOM_PIXELS) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(47, 0);
        2: set_idling(0, 47);
        default: set_idling(13, 13);
      endcase
      mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      w = $urandom_range(12);
      h = $urandom_range(9);
      frames = $urandom_range(3, 1);
      set_regs(mode, 3'($urandom_range(7)), CFG_BITS'(w), CFG_BITS'(h));
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      send_run(frames * w * h, FILL_RANDOM);
      sent += frames * w * h;
      wait_idle();
      phase++;
    end

    if (mismatches == 0) begin
      $display("phase_triplet_pixel_binning_tb OK");
    end else begin
      $display("phase_triplet_pixel_binning_tb NOT OK");
    end
    $finish;
  end

endmodule
